// ----- rtl/core/hkm_pkg.sv -----
// ----------------------------------------------------------------------------
// hkm_pkg
// Shared types and constants of the handle to key map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hkm_pkg;

	localparam int CMD_W    = 3;
	localparam int KEY_W    = 64;
	localparam int HANDLE_W = 10;
	localparam int STATUS_W = 3;
	localparam int SH_W     = 6;

	// multiplicative hash constant
	localparam logic [31:0] HASH_MULT = 32'd2654435761;

	typedef enum logic [CMD_W-1:0] {
		CMD_CREATE        = 3'd0,
		CMD_DESTROY       = 3'd1,
		CMD_SET           = 3'd2,
		CMD_LOOKUP_KEY    = 3'd3,
		CMD_LOOKUP_HANDLE = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_RANGE     = 3'd1,
		ST_ALREADY   = 3'd2,
		ST_EXHAUSTED = 3'd3,
		ST_NOTFOUND  = 3'd4,
		ST_BUSY      = 3'd5,
		ST_FULL      = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EVAL,
		S_HASH,
		S_PROBE,
		S_CHECK,
		S_OUT
	} state_t;

endpackage

// ----- rtl/core/hkm_cmd_if.sv -----
// ----------------------------------------------------------------------------
// hkm_cmd_if
// Command channel: valid/ready handshake carrying command, key and handle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hkm_cmd_if;

	logic                          valid;
	logic                          ready;
	logic [hkm_pkg::CMD_W-1:0]     command;
	logic [hkm_pkg::KEY_W-1:0]     key;
	logic [hkm_pkg::HANDLE_W-1:0]  handle;

	modport source (output valid, output command, output key, output handle, input ready);
	modport sink   (input valid, input command, input key, input handle, output ready);

endinterface

// ----- rtl/core/hkm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// hkm_rsp_if
// Response channel: valid/ready handshake carrying status, handle and key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hkm_rsp_if;

	logic                          valid;
	logic                          ready;
	logic [hkm_pkg::STATUS_W-1:0]  status;
	logic [hkm_pkg::HANDLE_W-1:0]  handle_out;
	logic [hkm_pkg::KEY_W-1:0]     key_out;

	modport source (output valid, output status, output handle_out, output key_out, input ready);
	modport sink   (input valid, input status, input handle_out, input key_out, output ready);

endinterface

// ----- rtl/core/handle_to_key_bidirectional_map.sv -----
// ----------------------------------------------------------------------------
// handle_to_key_bidirectional_map
// Maps small handles to 64-bit keys and keys back to handles.
//
// cmd carries one command per transaction (create, destroy, set, lookup by
// key, lookup by handle); rsp returns exactly one result per command.
// After reset the forward and reverse key memories are swept to zero, one
// entry a cycle, over max(HANDLE_COUNT, REVERSE_SLOTS) entries (2048 at the
// defaults); cmd.ready stays low during the sweep.
// Commands are taken one at a time. Destroy, set, lookup by handle and
// illegal codes go from accept through the read, evaluate and output states
// to rsp.valid. Create and lookup by key also probe reverse slots, with one
// read and one compare per probed slot, after 33 - clog2(REVERSE_SLOTS)
// remainder steps when REVERSE_SLOTS is not a power of two; the probe loop
// over the reverse memory port sets the rate.
// The result sits in an output register: while rsp is stalled the next
// command is still accepted and worked on, and it waits for the register
// to free before its own result is shown.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module handle_to_key_bidirectional_map #(
	parameter int HANDLE_COUNT  = 1024,
	parameter int REVERSE_SLOTS = 2048
) (
	input  logic            clk,
	input  logic            arst_n,
	hkm_cmd_if.sink         cmd,
	hkm_rsp_if.source       rsp
);

	localparam int HW    = $clog2(HANDLE_COUNT);
	localparam int NW    = $clog2(HANDLE_COUNT + 1);
	localparam int RW    = $clog2(REVERSE_SLOTS);
	localparam int CLR_N = (HANDLE_COUNT > REVERSE_SLOTS) ? HANDLE_COUNT : REVERSE_SLOTS;
	localparam int CW    = $clog2(CLR_N);
	localparam int SH0   = 32 - RW;
	localparam bit R_POW2 = ((REVERSE_SLOTS & (REVERSE_SLOTS - 1)) == 0);

	localparam int KW = hkm_pkg::KEY_W;
	localparam int OW = hkm_pkg::HANDLE_W;

	// memories
	logic [KW-1:0] fwd_mem [HANDLE_COUNT];
	logic [KW-1:0] rev_key_mem [REVERSE_SLOTS];
	logic [HW-1:0] rev_hdl_mem [REVERSE_SLOTS];

	logic          fwd_we, fwd_re;
	logic [HW-1:0] fwd_wa, fwd_ra;
	logic [KW-1:0] fwd_wd;
	logic [KW-1:0] fwd_rd_q;

	logic          rev_we, rev_re;
	logic [RW-1:0] rev_wa, rev_ra;
	logic [KW-1:0] rev_wk;
	logic [HW-1:0] rev_wh;
	logic [KW-1:0] rev_key_q;
	logic [HW-1:0] rev_hdl_q;

	// control state
	hkm_pkg::state_t state_q, state_d;
	logic [CW-1:0]   clr_q, clr_d;
	logic [NW-1:0]   nh_q, nh_d;
	logic            out_valid_q, out_valid_d;

	// payload
	logic [hkm_pkg::CMD_W-1:0] cmd_q, cmd_d;
	logic [KW-1:0]             key_q, key_d;
	logic [OW-1:0]             handle_q, handle_d;
	logic [31:0]               rem_q, rem_d;
	logic [hkm_pkg::SH_W-1:0]  sh_q, sh_d;
	logic [RW-1:0]             slot_q, slot_d;
	logic [RW-1:0]             probe_q, probe_d;
	hkm_pkg::status_t          res_status_q, res_status_d;
	logic [OW-1:0]             res_hout_q, res_hout_d;
	logic [KW-1:0]             res_kout_q, res_kout_d;
	hkm_pkg::status_t          out_status_q, out_status_d;
	logic [OW-1:0]             out_hout_q, out_hout_d;
	logic [KW-1:0]             out_kout_q, out_kout_d;

	logic [31:0]   prod_lo;
	logic [63:0]   dv;
	logic [31:0]   rem_nx;
	logic [RW-1:0] slot_nx;
	logic          h_ok;
	logic          cmd_ready;

	assign prod_lo = key_q[31:0] * hkm_pkg::HASH_MULT;
	assign dv      = 64'(REVERSE_SLOTS) << sh_q;
	assign rem_nx  = ({32'b0, rem_q} >= dv) ? (rem_q - dv[31:0]) : rem_q;
	assign slot_nx = (slot_q == RW'(REVERSE_SLOTS - 1)) ? '0 : slot_q + RW'(1);
	assign h_ok    = (32'(handle_q) < 32'(nh_q)) && (32'(handle_q) < HANDLE_COUNT)
		&& (fwd_rd_q != '0);

	always_comb begin
		state_d      = state_q;
		clr_d        = clr_q;
		nh_d         = nh_q;
		out_valid_d  = out_valid_q;
		cmd_d        = cmd_q;
		key_d        = key_q;
		handle_d     = handle_q;
		rem_d        = rem_q;
		sh_d         = sh_q;
		slot_d       = slot_q;
		probe_d      = probe_q;
		res_status_d = res_status_q;
		res_hout_d   = res_hout_q;
		res_kout_d   = res_kout_q;
		out_status_d = out_status_q;
		out_hout_d   = out_hout_q;
		out_kout_d   = out_kout_q;
		fwd_we       = 1'b0;
		fwd_wa       = HW'(handle_q);
		fwd_wd       = '0;
		fwd_re       = 1'b0;
		fwd_ra       = HW'(handle_q);
		rev_we       = 1'b0;
		rev_wa       = slot_q;
		rev_wk       = key_q;
		rev_wh       = HW'(nh_q);
		rev_re       = 1'b0;
		rev_ra       = slot_q;
		cmd_ready    = 1'b0;

		if (out_valid_q && rsp.ready) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			hkm_pkg::S_CLEAR: begin
				fwd_we = (32'(clr_q) < HANDLE_COUNT);
				fwd_wa = HW'(clr_q);
				rev_we = (32'(clr_q) < REVERSE_SLOTS);
				rev_wa = RW'(clr_q);
				rev_wk = '0;
				rev_wh = '0;
				if (clr_q == CW'(CLR_N - 1)) begin
					state_d = hkm_pkg::S_IDLE;
				end else begin
					clr_d = clr_q + CW'(1);
				end
			end
			hkm_pkg::S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd.valid) begin
					cmd_d    = cmd.command;
					key_d    = cmd.key;
					handle_d = cmd.handle;
					state_d  = hkm_pkg::S_READ;
				end
			end
			hkm_pkg::S_READ: begin
				fwd_re  = 1'b1;
				fwd_ra  = (cmd_q == hkm_pkg::CMD_CREATE) ? HW'(nh_q) : HW'(handle_q);
				rem_d   = prod_lo;
				sh_d    = hkm_pkg::SH_W'(SH0);
				probe_d = '0;
				state_d = hkm_pkg::S_EVAL;
			end
			hkm_pkg::S_EVAL: begin
				res_status_d = hkm_pkg::ST_RANGE;
				res_hout_d   = '0;
				res_kout_d   = '0;
				state_d      = hkm_pkg::S_OUT;
				slot_d       = RW'(rem_q);
				case (cmd_q)
					hkm_pkg::CMD_CREATE: begin
						if (32'(nh_q) >= HANDLE_COUNT) begin
							res_status_d = hkm_pkg::ST_EXHAUSTED;
						end else if (fwd_rd_q != '0) begin
							res_status_d = hkm_pkg::ST_BUSY;
						end else begin
							state_d = R_POW2 ? hkm_pkg::S_PROBE : hkm_pkg::S_HASH;
						end
					end
					hkm_pkg::CMD_DESTROY: begin
						if (h_ok) begin
							fwd_we       = 1'b1;
							res_status_d = hkm_pkg::ST_OK;
							if (32'(handle_q) == 32'(nh_q) - 32'd1) begin
								nh_d = nh_q - NW'(1);
							end
						end else begin
							res_status_d = hkm_pkg::ST_NOTFOUND;
						end
					end
					hkm_pkg::CMD_SET: begin
						if (handle_q == '0 || 32'(handle_q) >= HANDLE_COUNT) begin
							res_status_d = hkm_pkg::ST_RANGE;
						end else if (fwd_rd_q != '0) begin
							res_status_d = hkm_pkg::ST_ALREADY;
						end else begin
							fwd_we       = 1'b1;
							fwd_wd       = key_q;
							res_status_d = hkm_pkg::ST_OK;
							res_hout_d   = handle_q;
						end
					end
					hkm_pkg::CMD_LOOKUP_KEY: begin
						state_d = R_POW2 ? hkm_pkg::S_PROBE : hkm_pkg::S_HASH;
					end
					hkm_pkg::CMD_LOOKUP_HANDLE: begin
						if (h_ok) begin
							res_status_d = hkm_pkg::ST_OK;
							res_hout_d   = handle_q;
							res_kout_d   = fwd_rd_q;
						end else begin
							res_status_d = hkm_pkg::ST_NOTFOUND;
						end
					end
					default: begin
						res_status_d = hkm_pkg::ST_RANGE;
					end
				endcase
			end
			hkm_pkg::S_HASH: begin
				// one restoring remainder step per cycle
				rem_d = rem_nx;
				if (sh_q == '0) begin
					slot_d  = RW'(rem_nx);
					state_d = hkm_pkg::S_PROBE;
				end else begin
					sh_d = sh_q - hkm_pkg::SH_W'(1);
				end
			end
			hkm_pkg::S_PROBE: begin
				rev_re  = 1'b1;
				state_d = hkm_pkg::S_CHECK;
			end
			hkm_pkg::S_CHECK: begin
				state_d = hkm_pkg::S_PROBE;
				if (cmd_q == hkm_pkg::CMD_CREATE) begin
					if (rev_key_q == '0) begin
						fwd_we       = 1'b1;
						fwd_wa       = HW'(nh_q);
						fwd_wd       = key_q;
						rev_we       = 1'b1;
						nh_d         = nh_q + NW'(1);
						res_status_d = hkm_pkg::ST_OK;
						res_hout_d   = OW'(nh_q);
						state_d      = hkm_pkg::S_OUT;
					end else if (probe_q == RW'(REVERSE_SLOTS - 1)) begin
						res_status_d = hkm_pkg::ST_FULL;
						state_d      = hkm_pkg::S_OUT;
					end
				end else begin
					if (rev_key_q == '0) begin
						res_status_d = hkm_pkg::ST_NOTFOUND;
						state_d      = hkm_pkg::S_OUT;
					end else if (rev_key_q == key_q) begin
						res_status_d = hkm_pkg::ST_OK;
						res_hout_d   = OW'(rev_hdl_q);
						state_d      = hkm_pkg::S_OUT;
					end else if (probe_q == RW'(REVERSE_SLOTS - 1)) begin
						res_status_d = hkm_pkg::ST_NOTFOUND;
						state_d      = hkm_pkg::S_OUT;
					end
				end
				if (state_d == hkm_pkg::S_PROBE) begin
					slot_d  = slot_nx;
					probe_d = probe_q + RW'(1);
				end
			end
			hkm_pkg::S_OUT: begin
				if (!out_valid_q || rsp.ready) begin
					out_valid_d  = 1'b1;
					out_status_d = res_status_q;
					out_hout_d   = res_hout_q;
					out_kout_d   = res_kout_q;
					state_d      = hkm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = hkm_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hkm_pkg::S_CLEAR;
			clr_q       <= '0;
			nh_q        <= NW'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= clr_d;
			nh_q        <= nh_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q        <= cmd_d;
		key_q        <= key_d;
		handle_q     <= handle_d;
		rem_q        <= rem_d;
		sh_q         <= sh_d;
		slot_q       <= slot_d;
		probe_q      <= probe_d;
		res_status_q <= res_status_d;
		res_hout_q   <= res_hout_d;
		res_kout_q   <= res_kout_d;
		out_status_q <= out_status_d;
		out_hout_q   <= out_hout_d;
		out_kout_q   <= out_kout_d;
	end

	always_ff @(posedge clk) begin
		if (fwd_we) begin
			fwd_mem[fwd_wa] <= fwd_wd;
		end
		if (fwd_re) begin
			fwd_rd_q <= fwd_mem[fwd_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (rev_we) begin
			rev_key_mem[rev_wa] <= rev_wk;
			rev_hdl_mem[rev_wa] <= rev_wh;
		end
		if (rev_re) begin
			rev_key_q <= rev_key_mem[rev_ra];
			rev_hdl_q <= rev_hdl_mem[rev_ra];
		end
	end

	assign cmd.ready      = cmd_ready;
	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.handle_out = out_hout_q;
	assign rsp.key_out    = out_kout_q;

`ifndef SYNTH
	// an accepted transaction always starts the forward read
	a_accept_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> state_q == hkm_pkg::S_READ)
		else $error("accepted command did not start");

	// a new result only comes out of the output state
	a_rsp_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q) == hkm_pkg::S_OUT)
		else $error("result shown outside output state");

	// the handle counter moves only on a finished create or destroy
	a_counter_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(nh_q) |-> ($past(state_q) == hkm_pkg::S_EVAL
			|| $past(state_q) == hkm_pkg::S_CHECK))
		else $error("handle counter changed unexpectedly");
`endif

endmodule
